// ===== rtl/link_recovery_escalation_watchdog_unit_defines.svh =====
// Assertion macros shared by the watchdog checker.
`ifndef LINK_RECOVERY_ESCALATION_WATCHDOG_UNIT_DEFINES_SVH
`define LINK_RECOVERY_ESCALATION_WATCHDOG_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, muted during reset.
`define LREW_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lrew check failed");

// Next-cycle implication, sampled on the rising clock, muted during reset.
`define LREW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lrew check failed");

`endif

// ===== rtl/lrew_pkg.sv =====
// Package: types and constants of the link recovery watchdog.
`timescale 1ns / 1ps
package lrew_pkg;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_UP   = 2'd1,
    CMD_DOWN = 2'd2
  } lrew_cmd_t;

  typedef enum logic [2:0] {
    PH_OK        = 3'd0,
    PH_WAIT      = 3'd1,
    PH_BURST     = 3'd2,
    PH_RECONNECT = 3'd3,
    PH_RESTART   = 3'd4
  } lrew_phase_t;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] REG_BURST_INTERVAL  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SOFT_RECONNECT  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_HARD_RESTART    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_OFFLINE_CONNECT = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OFFLINE_RESTART = 3'd4;

  localparam logic [31:0] BURST_INTERVAL_RST  = 32'd5000;
  localparam logic [31:0] SOFT_RECONNECT_RST  = 32'd30000;
  localparam logic [31:0] HARD_RESTART_RST    = 32'd90000;
  localparam logic [31:0] OFFLINE_CONNECT_RST = 32'd20000;
  localparam logic [31:0] OFFLINE_RESTART_RST = 32'd60000;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] now_ms;
    logic        ack_fresh;
  } lrew_in_t;

  typedef struct packed {
    logic [2:0] recovery_phase;
    logic       kick_root;
    logic       disconnect_reconnect;
    logic       restart_service;
    logic       connect_attempt;
    logic       link_up;
  } lrew_out_t;

  typedef struct packed {
    logic [31:0] burst_interval_ms;
    logic [31:0] soft_reconnect_ms;
    logic [31:0] hard_restart_ms;
    logic [31:0] offline_connect_ms;
    logic [31:0] offline_restart_ms;
  } lrew_cfg_t;

endpackage

// ===== rtl/lrew_stream_if.sv =====
// Interface: valid/ready stream channel with a typed payload.
`timescale 1ns / 1ps
interface lrew_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/lrew_cfg_regs.sv =====
// Module: configuration register file of the watchdog.
`timescale 1ns / 1ps
module lrew_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lrew_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [lrew_pkg::CfgDataW-1:0]   cfg_data,
  output lrew_pkg::lrew_cfg_t             cfg
);
  import lrew_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.burst_interval_ms  <= BURST_INTERVAL_RST;
      cfg.soft_reconnect_ms  <= SOFT_RECONNECT_RST;
      cfg.hard_restart_ms    <= HARD_RESTART_RST;
      cfg.offline_connect_ms <= OFFLINE_CONNECT_RST;
      cfg.offline_restart_ms <= OFFLINE_RESTART_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BURST_INTERVAL:  cfg.burst_interval_ms  <= cfg_data;
        REG_SOFT_RECONNECT:  cfg.soft_reconnect_ms  <= cfg_data;
        REG_HARD_RESTART:    cfg.hard_restart_ms    <= cfg_data;
        REG_OFFLINE_CONNECT: cfg.offline_connect_ms <= cfg_data;
        REG_OFFLINE_RESTART: cfg.offline_restart_ms <= cfg_data;
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/lrew_core.sv =====
// Module: supervision state and single-pass recovery decision logic.
`timescale 1ns / 1ps
module lrew_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  lrew_pkg::lrew_in_t  item,
  input  lrew_pkg::lrew_cfg_t cfg,
  output lrew_pkg::lrew_out_t result
);
  import lrew_pkg::*;

  logic        connected, connected_next;
  lrew_phase_t phase, phase_next;
  logic [31:0] unhealthy_since, unhealthy_since_next;
  logic [31:0] last_burst_time, last_burst_time_next;
  logic [31:0] last_soft_time, last_soft_time_next;
  logic [31:0] last_hard_time, last_hard_time_next;
  logic [31:0] offline_since, offline_since_next;
  logic [31:0] last_connect_time, last_connect_time_next;
  logic [31:0] last_restart_time, last_restart_time_next;

  logic [31:0] now;
  logic [31:0] unh_eff;
  logic [31:0] up_down;
  logic [31:0] off_down;
  logic        burst_ok, hard_due, soft_due, conn_due, rest_due;
  logic        kick, reconnect, restart, conn;

  assign now      = item.now_ms;
  assign unh_eff  = (unhealthy_since == 32'd0) ? now : unhealthy_since;
  assign up_down  = now - unh_eff;
  assign off_down = now - offline_since;

  // Spacing checks; an unset last time always passes on the link-up side.
  assign burst_ok = (last_burst_time == 32'd0) ||
                    ((now - last_burst_time) >= cfg.burst_interval_ms);
  assign hard_due = (up_down >= cfg.hard_restart_ms) &&
                    ((last_hard_time == 32'd0) ||
                     ((now - last_hard_time) >= cfg.hard_restart_ms));
  assign soft_due = (up_down >= cfg.soft_reconnect_ms) &&
                    ((last_soft_time == 32'd0) ||
                     ((now - last_soft_time) >= cfg.soft_reconnect_ms));
  // Offline side compares against stored times even when they are zero.
  assign conn_due = (off_down >= cfg.offline_connect_ms) &&
                    ((now - last_connect_time) >= cfg.offline_connect_ms);
  assign rest_due = (off_down >= cfg.offline_restart_ms) &&
                    ((now - last_restart_time) >= cfg.offline_restart_ms);

  always_comb begin
    connected_next         = connected;
    phase_next             = phase;
    unhealthy_since_next   = unhealthy_since;
    last_burst_time_next   = last_burst_time;
    last_soft_time_next    = last_soft_time;
    last_hard_time_next    = last_hard_time;
    offline_since_next     = offline_since;
    last_connect_time_next = last_connect_time;
    last_restart_time_next = last_restart_time;
    kick      = 1'b0;
    reconnect = 1'b0;
    restart   = 1'b0;
    conn      = 1'b0;
    case (item.command)
      CMD_UP: begin
        connected_next         = 1'b1;
        offline_since_next     = 32'd0;
        last_connect_time_next = 32'd0;
        phase_next             = PH_WAIT;
        unhealthy_since_next   = now;
        last_burst_time_next   = 32'd0;
        last_soft_time_next    = 32'd0;
        last_hard_time_next    = 32'd0;
      end
      CMD_DOWN: begin
        if (connected || (offline_since == 32'd0)) begin
          offline_since_next = now;
        end
        connected_next       = 1'b0;
        phase_next           = PH_OK;
        unhealthy_since_next = 32'd0;
        last_burst_time_next = 32'd0;
      end
      CMD_TICK: begin
        if (connected) begin
          if (item.ack_fresh) begin
            phase_next           = PH_OK;
            unhealthy_since_next = 32'd0;
            last_burst_time_next = 32'd0;
            last_soft_time_next  = 32'd0;
            last_hard_time_next  = 32'd0;
          end else begin
            unhealthy_since_next = unh_eff;
            if (up_down >= cfg.hard_restart_ms) begin
              phase_next = PH_RESTART;
            end else if (up_down >= cfg.soft_reconnect_ms) begin
              phase_next = PH_RECONNECT;
            end else if (up_down >= cfg.burst_interval_ms) begin
              phase_next = PH_BURST;
            end else begin
              phase_next = PH_WAIT;
            end
            if (burst_ok) begin
              last_burst_time_next = now;
              kick = 1'b1;
            end
            if (hard_due) begin
              // Hard restart drops the link; link was up, so stamp offline.
              last_hard_time_next  = now;
              restart              = 1'b1;
              offline_since_next   = now;
              connected_next       = 1'b0;
              phase_next           = PH_OK;
              unhealthy_since_next = 32'd0;
              last_burst_time_next = 32'd0;
            end else if (soft_due) begin
              last_soft_time_next = now;
              reconnect = 1'b1;
            end
          end
        end else if (offline_since == 32'd0) begin
          offline_since_next = now;
        end else begin
          if (conn_due) begin
            last_connect_time_next = now;
            conn = 1'b1;
          end
          if (rest_due) begin
            last_restart_time_next = now;
            last_connect_time_next = now;
            restart                = 1'b1;
            connected_next         = 1'b0;
            phase_next             = PH_OK;
            unhealthy_since_next   = 32'd0;
            last_burst_time_next   = 32'd0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      connected         <= 1'b0;
      phase             <= PH_OK;
      unhealthy_since   <= 32'd0;
      last_burst_time   <= 32'd0;
      last_soft_time    <= 32'd0;
      last_hard_time    <= 32'd0;
      offline_since     <= 32'd0;
      last_connect_time <= 32'd0;
      last_restart_time <= 32'd0;
    end else if (step) begin
      connected         <= connected_next;
      phase             <= phase_next;
      unhealthy_since   <= unhealthy_since_next;
      last_burst_time   <= last_burst_time_next;
      last_soft_time    <= last_soft_time_next;
      last_hard_time    <= last_hard_time_next;
      offline_since     <= offline_since_next;
      last_connect_time <= last_connect_time_next;
      last_restart_time <= last_restart_time_next;
    end
  end

  assign result.recovery_phase       = phase_next;
  assign result.kick_root            = kick;
  assign result.disconnect_reconnect = reconnect;
  assign result.restart_service      = restart;
  assign result.connect_attempt      = conn;
  assign result.link_up              = connected_next;
endmodule

// ===== rtl/link_recovery_escalation_watchdog_unit.sv =====
// Top level: link recovery escalation watchdog with input and result registers.
`timescale 1ns / 1ps
// Link supervision watchdog. Each transfer on in_ch is a tick, a link-up or a
// link-down event stamped with a 32-bit millisecond time; every transfer gives
// exactly one transfer on out_ch carrying the recovery phase, the burst, soft
// reconnect, service restart and connect requests, and the link state. An item
// passes first through the input register, then through the decision logic
// into the result register. The supervision state is updated in the same edge
// that loads the result, so the next item sees it at once, and the block sustains
// one item per clock unless out_ch stalls it. Backpressure on out_ch
// holds the result register and, through it, the input register. Write the
// five interval registers through cfg_we/cfg_index/cfg_data only while no
// item is in flight; writes to indexes beyond the last register are dropped.
module link_recovery_escalation_watchdog_unit (
  input  logic                          clk,
  input  logic                          rst,
  lrew_stream_if.sink                   in_ch,
  lrew_stream_if.source                 out_ch,
  input  logic                          cfg_we,
  input  logic [lrew_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [lrew_pkg::CfgDataW-1:0] cfg_data
);
  import lrew_pkg::*;

  lrew_cfg_t cfg;
  lrew_in_t  in_reg;
  logic      in_reg_valid;
  lrew_out_t out_reg;
  logic      out_reg_valid;
  lrew_out_t result;
  logic      advance;

  // Move the held item into the result register when that slot frees up.
  assign advance     = in_reg_valid && (!out_reg_valid || out_ch.ready);
  assign in_ch.ready = !in_reg_valid || advance;

  lrew_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lrew_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_reg),
    .cfg    (cfg),
    .result (result)
  );

  // Input register: capture on transfer, drop once advanced.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_reg_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_reg <= in_ch.data;
    end
  end

  // Result register: load on advance, hold while the sink stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_reg_valid <= 1'b0;
    end else if (advance) begin
      out_reg_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= result;
    end
  end

  assign out_ch.valid = out_reg_valid;
  assign out_ch.data  = out_reg;
endmodule

// ===== rtl/lrew_checker.sv =====
// Checker: port-level assertions on the watchdog results, bound to the top.
`timescale 1ns / 1ps
`include "link_recovery_escalation_watchdog_unit_defines.svh"
module lrew_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input lrew_pkg::lrew_out_t out_data
);
  import lrew_pkg::*;

  // A service restart always leaves the link down.
  `LREW_ASSERT_NOW(a_restart_drops_link, clk, rst, out_valid && out_data.restart_service, !out_data.link_up)
  // While the link is down the phase reads as ok.
  `LREW_ASSERT_NOW(a_down_phase_ok, clk, rst, out_valid && !out_data.link_up, out_data.recovery_phase == PH_OK)
  // Soft reconnect only on a live link and never with a restart or connect.
  `LREW_ASSERT_NOW(a_soft_exclusive, clk, rst, out_valid && out_data.disconnect_reconnect, out_data.link_up && !out_data.restart_service && !out_data.connect_attempt)
  // A stalled result holds.
  `LREW_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule

bind link_recovery_escalation_watchdog_unit lrew_checker u_lrew_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
